>>> rtl/core/pdrb_pkg.sv
// Package for the job dispatcher: queue sizing, job record and FIFO control types,
// action and status codes, and count widening helpers.
// Depends on nothing; every module of the dispatcher imports it.
`default_nettype none

package pdrb_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 16;
    localparam int SUM_W       = DATA_W + 1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] start;
        logic [15:0] cpu;
        logic [7:0]  io;
    } t_job;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_fifo_ctl;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_SWITCH  = 3'd1;
    localparam logic [2:0] ACT_IO_DONE = 3'd2;
    localparam logic [2:0] ACT_TICK    = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    localparam logic [3:0] ST_ADDED         = 4'd0;
    localparam logic [3:0] ST_FULL          = 4'd1;
    localparam logic [3:0] ST_NO_JOBS       = 4'd2;
    localparam logic [3:0] ST_ONLY_BLOCKED  = 4'd3;
    localparam logic [3:0] ST_SWITCHED      = 4'd4;
    localparam logic [3:0] ST_BLOCKED_EMPTY = 4'd5;
    localparam logic [3:0] ST_UNBLOCKED     = 4'd6;
    localparam logic [3:0] ST_STARTED       = 4'd7;
    localparam logic [3:0] ST_DECREMENTED   = 4'd8;
    localparam logic [3:0] ST_BLOCKED       = 4'd9;
    localparam logic [3:0] ST_FINISHED      = 4'd10;
    localparam logic [3:0] ST_CLEARED       = 4'd11;
    localparam logic [3:0] ST_UNKNOWN       = 4'd12;

    localparam logic [7:0] IO_BLOCK = 8'd1;

    function automatic logic [DATA_W-1:0] cnt_to_data(input logic [CNT_W-1:0] c);
        logic [CNT_W+DATA_W-1:0] t;
        t = {{DATA_W{1'b0}}, c};
        return t[DATA_W-1:0];
    endfunction

    function automatic logic [4:0] cnt_to_port(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] t;
        t = {5'b0, c};
        return t[4:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pdrb_fifo.sv
// Job record FIFO: a memory of QUEUE_DEPTH entries with head, tail and fill registers.
// The head entry is read into a register every cycle. Depends on pdrb_pkg.
`default_nettype none

module pdrb_fifo
    import pdrb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_fifo_ctl        i_ctl,
    input  wire t_job             i_wr_data,
    output logic      [CNT_W-1:0] o_fill,
    output t_job                  o_rd_data
);

    t_job             r_mem [QUEUE_DEPTH];
    t_job             r_rd_data;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] n_tail;
    logic [CNT_W-1:0] n_fill;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end else begin
            if (i_ctl.pop) begin
                n_head = wrap_inc(r_head);
            end
            if (i_ctl.push) begin
                n_tail = wrap_inc(r_tail);
            end
            if (i_ctl.push && !i_ctl.pop) begin
                n_fill = r_fill + CNT_W'(1);
            end else if (i_ctl.pop && !i_ctl.push) begin
                n_fill = r_fill - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear) begin
            r_mem[r_tail] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign o_fill    = r_fill;
    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/pdrb_alu.sv
// Shared adder of the dispatcher with a registered sum. It forms the occupancy
// total for the full check and the decremented cpu count. Depends on pdrb_pkg.
`default_nettype none

module pdrb_alu
    import pdrb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    input  wire logic              i_cin,
    output logic      [SUM_W-1:0]  o_sum
);

    logic [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        r_sum <= {1'b0, i_a} + {1'b0, i_b} + SUM_W'(i_cin);
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> rtl/core/process_dispatcher_ready_blocked_top.sv
// Top level of the job dispatcher: the action sequencer, the running job record,
// and the ready and blocked FIFOs. Depends on pdrb_pkg, pdrb_fifo and pdrb_alu.
`default_nettype none

// A transaction is taken when start is high and busy is low. Its one result
// appears on the o_ ports for a single cycle with o_done high, in the first cycle
// with busy low again. The receiver cannot stall it, so it must capture it then.
// Switch, clear, a tick with nothing running, an unknown action and I/O complete
// with no blocked jobs finish from the execute state. Add and any tick on a running
// job go on to the S_ADD or S_TICK state, because the shared adder is registered.
// I/O complete moves the n blocked jobs one by one, in S_DRAIN with S_DWAIT between
// moves, since each move waits for the registered read of the blocked FIFO head.

module process_dispatcher_ready_blocked_top
    import pdrb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_job_id,
    input  wire logic [15:0] i_job_start,
    input  wire logic [15:0] i_job_cpu,
    input  wire logic [7:0]  i_job_io,
    output logic             o_done,
    output logic [3:0]       o_status,
    output logic             o_running_valid,
    output logic [15:0]      o_running_id,
    output logic [15:0]      o_running_start,
    output logic [15:0]      o_running_cpu,
    output logic [7:0]       o_running_io,
    output logic [4:0]       o_ready_count,
    output logic [4:0]       o_blocked_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_TICK,
        S_DRAIN,
        S_DWAIT
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic        r_done;
    logic        n_done;
    logic [3:0]  r_status;
    logic [3:0]  n_status;
    logic [2:0]  r_act;
    logic [2:0]  n_act;
    t_job        r_job;
    t_job        n_job;
    t_job        r_run;
    t_job        n_run;
    logic        r_run_valid;
    logic        n_run_valid;

    t_fifo_ctl         rdy_ctl;
    t_fifo_ctl         blk_ctl;
    t_job              rdy_wr;
    t_job              blk_wr;
    t_job              rdy_data;
    t_job              blk_data;
    logic [CNT_W-1:0]  rdy_fill;
    logic [CNT_W-1:0]  blk_fill;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic              alu_cin;
    logic [SUM_W-1:0]  alu_sum;
    logic [3:0]        idle_status;
    logic [15:0]       cpu_dec;

    pdrb_fifo u_ready (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rdy_ctl),
        .i_wr_data (rdy_wr),
        .o_fill    (rdy_fill),
        .o_rd_data (rdy_data)
    );

    pdrb_fifo u_blocked (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (blk_ctl),
        .i_wr_data (blk_wr),
        .o_fill    (blk_fill),
        .o_rd_data (blk_data)
    );

    pdrb_alu u_alu (
        .i_clk (i_clk),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_cin (alu_cin),
        .o_sum (alu_sum)
    );

    assign idle_status = (blk_fill == '0) ? ST_NO_JOBS : ST_ONLY_BLOCKED;
    assign cpu_dec     = alu_sum[15:0];

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_status    = r_status;
        n_act       = r_act;
        n_job       = r_job;
        n_run       = r_run;
        n_run_valid = r_run_valid;
        rdy_ctl     = '0;
        blk_ctl     = '0;
        rdy_wr      = r_job;
        blk_wr      = r_run;
        blk_wr.cpu  = '0;
        alu_a       = cnt_to_data(rdy_fill);
        alu_b       = cnt_to_data(blk_fill);
        alu_cin     = r_run_valid;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act       = i_action;
                    n_job.id    = i_job_id;
                    n_job.start = i_job_start;
                    n_job.cpu   = i_job_cpu;
                    n_job.io    = i_job_io;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_act)
                    ACT_ADD: begin
                        n_state = S_ADD;
                        n_done  = 1'b0;
                    end
                    ACT_SWITCH: begin
                        if (rdy_fill == '0) begin
                            n_status = idle_status;
                        end else begin
                            rdy_ctl.pop = 1'b1;
                            if (r_run_valid) begin
                                rdy_ctl.push = 1'b1;
                                rdy_wr       = r_run;
                            end
                            n_run       = rdy_data;
                            n_run_valid = 1'b1;
                            n_status    = ST_SWITCHED;
                        end
                    end
                    ACT_IO_DONE: begin
                        if (blk_fill == '0) begin
                            n_status = ST_BLOCKED_EMPTY;
                        end else begin
                            n_state = S_DRAIN;
                            n_done  = 1'b0;
                        end
                    end
                    ACT_TICK: begin
                        if (!r_run_valid) begin
                            if (rdy_fill == '0) begin
                                n_status = idle_status;
                            end else begin
                                rdy_ctl.pop = 1'b1;
                                n_run       = rdy_data;
                                n_run_valid = 1'b1;
                                n_status    = ST_STARTED;
                            end
                        end else begin
                            alu_a   = r_run.cpu;
                            alu_b   = '1;
                            alu_cin = 1'b0;
                            n_state = S_TICK;
                            n_done  = 1'b0;
                        end
                    end
                    ACT_CLEAR: begin
                        rdy_ctl.clear = 1'b1;
                        blk_ctl.clear = 1'b1;
                        n_run         = '0;
                        n_run_valid   = 1'b0;
                        n_status      = ST_CLEARED;
                    end
                    default: begin
                        n_status = ST_UNKNOWN;
                    end
                endcase
            end
            S_ADD: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (alu_sum >= SUM_W'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    rdy_ctl.push = 1'b1;
                    n_status     = ST_ADDED;
                end
            end
            S_TICK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (cpu_dec != '0) begin
                    n_run.cpu = cpu_dec;
                    n_status  = ST_DECREMENTED;
                end else begin
                    if (r_run.io == IO_BLOCK) begin
                        blk_ctl.push = 1'b1;
                        n_status     = ST_BLOCKED;
                    end else begin
                        n_status = ST_FINISHED;
                    end
                    if (rdy_fill == '0) begin
                        n_run       = '0;
                        n_run_valid = 1'b0;
                    end else begin
                        rdy_ctl.pop = 1'b1;
                        n_run       = rdy_data;
                        n_run_valid = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                rdy_ctl.push = 1'b1;
                rdy_wr       = blk_data;
                blk_ctl.pop  = 1'b1;
                if (blk_fill == CNT_W'(1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_UNBLOCKED;
                end else begin
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                n_state = S_DRAIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_run       <= '0;
            r_run_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_run       <= n_run;
            r_run_valid <= n_run_valid;
        end
        r_status <= n_status;
        r_act    <= n_act;
        r_job    <= n_job;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_running_valid = r_run_valid;
    assign o_running_id    = r_run.id;
    assign o_running_start = r_run.start;
    assign o_running_cpu   = r_run.cpu;
    assign o_running_io    = r_run.io;
    assign o_ready_count   = cnt_to_port(rdy_fill);
    assign o_blocked_count = cnt_to_port(blk_fill);

endmodule

`default_nettype wire
